### rtl/core/simple8b_packer_assert.svh
// assertion helpers for the simple-8b packer
`ifndef SIMPLE8B_PACKER_ASSERT_SVH
`define SIMPLE8B_PACKER_ASSERT_SVH

// clocked check, ignored while reset is held
`define S8B_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// clocked check that also holds during reset
`define S8B_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

### rtl/core/s8b_pkg.sv
// ----------------------------------------------------------------------------
// s8b_pkg
// Selector tables and shared constants of the simple-8b packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package s8b_pkg;

    localparam int SEL_W       = 4;
    localparam int PAYLOAD_W   = 60;
    localparam int BITS_W      = 6;
    localparam int COUNT_W     = 8;
    localparam int STORE_DEPTH = 60;
    localparam int ADDR_W      = 6;
    localparam int IN_W        = 32;
    localparam int OUT_TDATA_W = 72;

    localparam logic [SEL_W-1:0] SEL_ZERO240 = 4'd0;
    localparam logic [SEL_W-1:0] SEL_ZERO120 = 4'd1;
    localparam logic [SEL_W-1:0] SEL_MAX     = 4'd15;

    localparam logic KIND_PUSH  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // values per group
    function automatic logic [COUNT_W-1:0] grp_count(input logic [SEL_W-1:0] s);
        logic [COUNT_W-1:0] r;
        unique case (s)
            4'd0:  r = 8'd240;
            4'd1:  r = 8'd120;
            4'd2:  r = 8'd60;
            4'd3:  r = 8'd30;
            4'd4:  r = 8'd20;
            4'd5:  r = 8'd15;
            4'd6:  r = 8'd12;
            4'd7:  r = 8'd10;
            4'd8:  r = 8'd8;
            4'd9:  r = 8'd7;
            4'd10: r = 8'd6;
            4'd11: r = 8'd5;
            4'd12: r = 8'd4;
            4'd13: r = 8'd3;
            4'd14: r = 8'd2;
            4'd15: r = 8'd1;
        endcase
        return r;
    endfunction

    // bits per value
    function automatic logic [BITS_W-1:0] grp_bits(input logic [SEL_W-1:0] s);
        logic [BITS_W-1:0] r;
        unique case (s)
            4'd0:  r = 6'd0;
            4'd1:  r = 6'd0;
            4'd2:  r = 6'd1;
            4'd3:  r = 6'd2;
            4'd4:  r = 6'd3;
            4'd5:  r = 6'd4;
            4'd6:  r = 6'd5;
            4'd7:  r = 6'd6;
            4'd8:  r = 6'd7;
            4'd9:  r = 6'd8;
            4'd10: r = 6'd10;
            4'd11: r = 6'd12;
            4'd12: r = 6'd15;
            4'd13: r = 6'd20;
            4'd14: r = 6'd30;
            4'd15: r = 6'd60;
        endcase
        return r;
    endfunction

    // used payload bits of a full group
    function automatic logic [BITS_W-1:0] grp_total(input logic [SEL_W-1:0] s);
        logic [BITS_W-1:0] r;
        unique case (s)
            4'd0, 4'd1: r = 6'd0;
            4'd8, 4'd9: r = 6'd56;
            default:    r = 6'd60;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/simple8b_packer.sv
// ----------------------------------------------------------------------------
// simple8b_packer
// Simple-8b packer: buffers values and emits selector / payload groups.
// ----------------------------------------------------------------------------
// A push that fits the current group is taken in the idle state and the next
// request can follow right away. A push that overflows, or a flush request,
// runs the group sequencer: each group passes through a planning state; then,
// for groups with nonzero lanes, a gather state reads each value through the
// single read port of the value store, with registered read data; then an
// emit state passes the group to the output register. Zero-run groups skip
// the store. The input is not taken while groups are being built; the output
// register lets the next push arrive while the last group waits downstream.
`timescale 1ns / 1ps
`default_nettype none

`include "simple8b_packer_assert.svh"

module simple8b_packer #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [s8b_pkg::IN_W-1:0]          s_tdata,  // value
    input  wire logic [0:0]                        s_tuser,  // kind
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [s8b_pkg::OUT_TDATA_W-1:0]        m_tdata,  // payload, payload_bits
    output logic [s8b_pkg::SEL_W-1:0]              m_tuser,  // selector
    output logic                                   m_tlast
);
    import s8b_pkg::*;

    localparam int STORE_W = (VALUE_BITS < IN_W) ? VALUE_BITS : IN_W;

    typedef enum logic [1:0] {ST_IDLE, ST_PLAN, ST_GATHER, ST_EMIT} state_t;

    state_t               state_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [SEL_W-1:0]     wi_reg;
    logic                 push_reg;
    logic [STORE_W-1:0]   val_reg;
    logic [SEL_W-1:0]     ni0_reg;
    logic [ADDR_W-1:0]    base_reg;
    logic [SEL_W-1:0]     g_sel_reg;
    logic [COUNT_W-1:0]   g_take_reg;
    logic [BITS_W-1:0]    g_bits_reg;
    logic [BITS_W-1:0]    w_reg;
    logic [ADDR_W-1:0]    issue_reg;
    logic [ADDR_W-1:0]    recv_reg;
    logic [BITS_W-1:0]    pos_reg;
    logic [PAYLOAD_W-1:0] acc_reg;
    logic                 rd_valid_reg;
    logic [STORE_W-1:0]   rd_data_reg;
    logic                 m_valid_reg;
    logic [SEL_W-1:0]     m_sel_reg;
    logic [PAYLOAD_W-1:0] m_payload_reg;
    logic [BITS_W-1:0]    m_bits_reg;
    logic                 m_last_reg;

    logic [STORE_W-1:0]   mem [STORE_DEPTH];

    logic [STORE_W-1:0]   in_val;
    logic [BITS_W-1:0]    in_len;
    logic [SEL_W-1:0]     ni;
    logic [SEL_W-1:0]     ni0;
    logic [SEL_W-1:0]     gs;
    logic                 accept;
    logic                 overflow;
    logic                 out_free;
    logic [COUNT_W-1:0]   new_count;
    logic                 greedy;
    logic                 done_once;
    logic                 more_push;
    logic                 grp_last;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [STORE_W-1:0]   wr_data;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [PAYLOAD_W-1:0] lane_mask;
    logic [PAYLOAD_W-1:0] lane_val;

    assign in_val = s_tdata[STORE_W-1:0];
    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        in_len = '0;
        for (int i = 0; i < STORE_W; i++) begin
            if (in_val[i]) begin
                in_len = BITS_W'(i + 1);
            end
        end
    end

    // narrowest selector at or above the current one that fits the value
    always_comb begin
        ni  = SEL_MAX;
        ni0 = SEL_MAX;
        for (int k = 15; k >= 0; k--) begin
            if (grp_bits(SEL_W'(k)) >= in_len) begin
                ni0 = SEL_W'(k);
                if (SEL_W'(k) >= wi_reg) begin
                    ni = SEL_W'(k);
                end
            end
        end
    end

    // largest group the buffered count fills
    always_comb begin
        gs = SEL_MAX;
        for (int k = 15; k >= 0; k--) begin
            if (count_reg >= grp_count(SEL_W'(k))) begin
                gs = SEL_W'(k);
            end
        end
    end

    assign overflow  = count_reg >= grp_count(ni);
    assign out_free  = !m_valid_reg || m_tready;
    assign new_count = count_reg - g_take_reg;
    assign greedy    = (g_sel_reg != SEL_ZERO240) && (g_sel_reg != SEL_ZERO120);
    assign done_once = !greedy || (new_count == '0);
    assign more_push = new_count >= grp_count(ni0_reg);
    assign grp_last  = push_reg ? (done_once && !more_push) : (new_count == '0);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = count_reg[ADDR_W-1:0];
        wr_data = in_val;
        if (state_reg == ST_IDLE) begin
            wr_en = accept && (s_tuser[0] == KIND_PUSH) && !overflow
                    && (count_reg < COUNT_W'(STORE_DEPTH));
        end else if (state_reg == ST_EMIT) begin
            wr_en   = out_free && grp_last && push_reg
                      && (new_count < COUNT_W'(STORE_DEPTH));
            wr_addr = new_count[ADDR_W-1:0];
            wr_data = val_reg;
        end
    end

    assign rd_en     = (state_reg == ST_GATHER) && (issue_reg < g_take_reg[ADDR_W-1:0]);
    assign rd_addr   = base_reg + issue_reg;
    assign lane_mask = (PAYLOAD_W'(1) << w_reg) - PAYLOAD_W'(1);
    assign lane_val  = PAYLOAD_W'(rd_data_reg) & lane_mask;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            wi_reg       <= '0;
            push_reg     <= 1'b0;
            base_reg     <= '0;
            issue_reg    <= '0;
            recv_reg     <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            rd_valid_reg <= rd_en;
            // the emit state reloads the output register on its own
            if (m_valid_reg && m_tready && (state_reg != ST_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (s_tuser[0] == KIND_FLUSH) begin
                            push_reg <= 1'b0;
                            if (count_reg != '0) begin
                                state_reg <= ST_PLAN;
                            end
                        end else if (overflow) begin
                            push_reg  <= 1'b1;
                            val_reg   <= in_val;
                            ni0_reg   <= ni0;
                            state_reg <= ST_PLAN;
                        end else begin
                            count_reg <= count_reg + 1'b1;
                            wi_reg    <= ni;
                        end
                    end
                end
                ST_PLAN: begin
                    acc_reg   <= '0;
                    pos_reg   <= '0;
                    issue_reg <= '0;
                    recv_reg  <= '0;
                    if ((wi_reg == '0) && (count_reg >= grp_count(SEL_ZERO240))) begin
                        g_sel_reg  <= SEL_ZERO240;
                        g_take_reg <= count_reg;
                        g_bits_reg <= '0;
                        state_reg  <= ST_EMIT;
                    end else if ((wi_reg == '0)
                                 && (count_reg >= grp_count(SEL_ZERO120))) begin
                        g_sel_reg  <= SEL_ZERO120;
                        g_take_reg <= grp_count(SEL_ZERO120);
                        g_bits_reg <= '0;
                        state_reg  <= ST_EMIT;
                    end else begin
                        g_sel_reg  <= gs;
                        g_take_reg <= grp_count(gs);
                        g_bits_reg <= grp_total(gs);
                        w_reg      <= grp_bits(gs);
                        // all buffered values are zero while the width is zero
                        state_reg  <= (wi_reg == '0) ? ST_EMIT : ST_GATHER;
                    end
                end
                ST_GATHER: begin
                    if (rd_en) begin
                        issue_reg <= issue_reg + 1'b1;
                    end
                    if (rd_valid_reg) begin
                        acc_reg  <= acc_reg | (lane_val << pos_reg);
                        pos_reg  <= pos_reg + w_reg;
                        recv_reg <= recv_reg + 1'b1;
                        if ((recv_reg + 1'b1) == g_take_reg[ADDR_W-1:0]) begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        m_sel_reg     <= g_sel_reg;
                        m_payload_reg <= acc_reg;
                        m_bits_reg    <= g_bits_reg;
                        m_last_reg    <= grp_last;
                        if (grp_last && push_reg) begin
                            count_reg <= new_count + 1'b1;
                            wi_reg    <= ni0_reg;
                        end else begin
                            count_reg <= new_count;
                            if (done_once) begin
                                wi_reg <= '0;
                            end
                        end
                        base_reg <= (greedy && !done_once)
                                    ? base_reg + g_take_reg[ADDR_W-1:0] : '0;
                        state_reg <= grp_last ? ST_IDLE : ST_PLAN;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_sel_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(OUT_TDATA_W - PAYLOAD_W - BITS_W){1'b0}}, m_bits_reg, m_payload_reg};

    // a nonzero lane width keeps the buffer within the store
    `S8B_CHECK(a_width_count, (wi_reg != '0) |-> (count_reg <= COUNT_W'(STORE_DEPTH)), "count beyond store with nonzero width")
    `S8B_CHECK(a_read_range, rd_en |-> (rd_addr < ADDR_W'(STORE_DEPTH)), "store read out of range")
    `S8B_CHECK(a_gather_width, (state_reg == ST_GATHER) |-> (wi_reg != '0), "gather on a zero run")
    `S8B_CHECK(a_bits_code, m_valid_reg |-> ((m_bits_reg == 6'd0) || (m_bits_reg == 6'd56) || (m_bits_reg == 6'd60)), "bad payload bit count")

endmodule

`default_nettype wire
